// ===== design/bgsc_pkg.sv =====
package bgsc_pkg;

  // field widths
  localparam int unsigned CmdW    = 2;
  localparam int unsigned WordW   = 16;
  localparam int unsigned ChgW    = 27;
  localparam int unsigned CurW    = 27;
  localparam int unsigned VoltW   = 24;
  localparam int unsigned TempW   = 16;
  localparam int unsigned PctW    = 7;
  localparam int unsigned AvgW    = 27;
  localparam int unsigned CountW  = 32;

  // configuration register widths, indexes and reset values
  localparam int unsigned ResW     = 10;
  localparam int unsigned MvW      = 14;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 14;

  localparam logic [CfgIdxW-1:0] CfgIdxRes   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxEmpty = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxFull  = 2'd2;

  localparam logic [ResW-1:0] ResReset   = 10'd100;
  localparam logic [MvW-1:0]  EmptyReset = 14'd3000;
  localparam logic [MvW-1:0]  FullReset  = 14'd4200;

  // commands carried by an input word
  localparam logic [CmdW-1:0] CmdSample = 2'd0;
  localparam logic [CmdW-1:0] CmdRebase = 2'd1;
  localparam logic [CmdW-1:0] CmdClear  = 2'd2;

  // scale factors
  localparam logic [12:0] ChargeFactor  = 13'd6700;
  localparam logic [13:0] CurrentFactor = 14'd11770;
  localparam logic [11:0] UvPerCount    = 12'd2440;
  localparam logic [9:0]  UvPerMv       = 10'd1000;
  localparam logic [PctW-1:0] PctFull   = 7'd100;

  // internal widths
  localparam int unsigned UvW     = 24;
  localparam int unsigned ChgProdW = 28;
  localparam int unsigned CurProdW = 29;
  localparam int unsigned SumW    = 59;

  // serial divider
  localparam int unsigned DivNumW = 60;
  localparam int unsigned DivDenW = 32;
  localparam int unsigned DivQW   = 29;
  localparam int unsigned DivCntW = 5;

  localparam logic [DivCntW-1:0] QbitsChg = 5'd28;
  localparam logic [DivCntW-1:0] QbitsCur = 5'd29;
  localparam logic [DivCntW-1:0] QbitsPct = 5'd7;
  localparam logic [DivCntW-1:0] QbitsAvg = 5'd27;

  typedef enum logic [1:0] {
    OP_CHG,
    OP_CUR,
    OP_PCT,
    OP_AVG
  } div_op_e;

  typedef struct packed {
    logic    load;
    logic    start;
    div_op_e op;
    logic    update;
    logic    out_load;
  } ctrl_cmd_t;

endpackage

// ===== design/bgsc_div.sv =====
module bgsc_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [bgsc_pkg::DivNumW-1:0]        num_i,
  input  logic [bgsc_pkg::DivDenW-1:0]        den_i,
  input  logic [bgsc_pkg::DivCntW-1:0]        qbits_i,
  output logic                                done_o,
  output logic [bgsc_pkg::DivQW-1:0]          quot_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [bgsc_pkg::DivCntW-1:0]     cnt_q, cnt_d;
  logic [bgsc_pkg::DivNumW-1:0]     rem_q, rem_d;
  logic [bgsc_pkg::DivNumW-1:0]     dsh_q, dsh_d;
  logic [bgsc_pkg::DivQW-1:0]       quot_q, quot_d;
  logic                             ge;

  // restoring division, one quotient bit per cycle, msb first
  // caller guarantees num < den * 2^qbits
  assign ge = (rem_q >= dsh_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = qbits_i;
      rem_d  = num_i;
      dsh_d  = bgsc_pkg::DivNumW'(den_i) << (qbits_i - 5'd1);
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? (rem_q - dsh_q) : rem_q;
      dsh_d  = dsh_q >> 1;
      quot_d = {quot_q[bgsc_pkg::DivQW-2:0], ge};
      cnt_d  = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== design/bgsc_datapath.sv =====
module bgsc_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  bgsc_pkg::ctrl_cmd_t                    cmd_i,
  output logic                                   div_done_o,
  input  logic                                   cfg_we_i,
  input  logic [bgsc_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  logic [bgsc_pkg::CfgDataW-1:0]          cfg_wdata_i,
  input  logic [bgsc_pkg::CmdW-1:0]              cmd_word_i,
  input  logic signed [bgsc_pkg::WordW-1:0]      charge_word_i,
  input  logic signed [bgsc_pkg::WordW-1:0]      current_word_i,
  input  logic [bgsc_pkg::WordW-1:0]             voltage_word_i,
  input  logic signed [bgsc_pkg::WordW-1:0]      temperature_word_i,
  output logic signed [bgsc_pkg::ChgW-1:0]       charge_uah_o,
  output logic signed [bgsc_pkg::CurW-1:0]       current_ua_o,
  output logic [bgsc_pkg::VoltW-1:0]             voltage_uv_o,
  output logic signed [bgsc_pkg::TempW-1:0]      temperature_eighths_o,
  output logic [bgsc_pkg::PctW-1:0]              charge_percent_o,
  output logic signed [bgsc_pkg::AvgW-1:0]       average_current_ua_o,
  output logic [bgsc_pkg::CountW-1:0]            samples_counted_o
);

  // configuration
  logic [bgsc_pkg::ResW-1:0] res_q;
  logic [bgsc_pkg::MvW-1:0]  empty_q;
  logic [bgsc_pkg::MvW-1:0]  full_q;
  logic [bgsc_pkg::ResW-1:0] res_eff;

  // latched word
  logic [bgsc_pkg::CmdW-1:0]         cmd_q;
  logic                              chg_neg_q;
  logic                              cur_neg_q;
  logic [bgsc_pkg::ChgProdW-1:0]     chg_prod_q;
  logic [bgsc_pkg::CurProdW-1:0]     cur_prod_q;
  logic [bgsc_pkg::UvW-1:0]          volt_uv_q;
  logic [bgsc_pkg::UvW-1:0]          empty_uv_q;
  logic [bgsc_pkg::UvW-1:0]          full_uv_q;
  logic signed [bgsc_pkg::TempW-1:0] temp_q;
  logic [bgsc_pkg::WordW-1:0]        chg_mag;
  logic [bgsc_pkg::WordW-1:0]        cur_mag;

  // gauge state
  logic signed [31:0]                ref_q;
  logic signed [bgsc_pkg::ChgW-1:0]  last_rel_q;
  logic signed [bgsc_pkg::SumW-1:0]  sum_q;
  logic [bgsc_pkg::CountW-1:0]       total_q;

  // per-word results
  logic signed [bgsc_pkg::ChgW-1:0]  charge_q;
  logic signed [bgsc_pkg::CurW-1:0]  current_q;
  logic [bgsc_pkg::PctW-1:0]         pct_q;
  logic signed [bgsc_pkg::AvgW-1:0]  avg_q;

  // divider
  bgsc_pkg::div_op_e                 op_q;
  logic [bgsc_pkg::DivNumW-1:0]      div_num;
  logic [bgsc_pkg::DivDenW-1:0]      div_den;
  logic [bgsc_pkg::DivCntW-1:0]      div_qbits;
  logic                              div_done;
  logic [bgsc_pkg::DivQW-1:0]        div_quot;

  logic [bgsc_pkg::UvW-1:0]          volt_above;
  logic [30:0]                       pct_num;
  logic [bgsc_pkg::SumW-1:0]         sum_mag;
  logic signed [29:0]                quot_signed;
  logic signed [33:0]                chg_diff;
  logic signed [32:0]                rebase_sum;
  logic signed [bgsc_pkg::SumW-1:0]  sum_next;
  logic                              pct_low;
  logic                              pct_high;

  function automatic logic signed [26:0] sat27(input logic signed [33:0] v);
    logic signed [26:0] r;
    if (v > 34'sd67108863) begin
      r = 27'sd67108863;
    end else if (v < -34'sd67108864) begin
      r = -27'sd67108864;
    end else begin
      r = v[26:0];
    end
    return r;
  endfunction

  // a zero resistance counts as one milliohm
  assign res_eff = (res_q == '0) ? 10'd1 : res_q;

  assign chg_mag = charge_word_i[15] ? (~charge_word_i + 16'd1) : charge_word_i;
  assign cur_mag = current_word_i[15] ? (~current_word_i + 16'd1) : current_word_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q   <= bgsc_pkg::ResReset;
      empty_q <= bgsc_pkg::EmptyReset;
      full_q  <= bgsc_pkg::FullReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bgsc_pkg::CfgIdxRes:   res_q   <= cfg_wdata_i[bgsc_pkg::ResW-1:0];
        bgsc_pkg::CfgIdxEmpty: empty_q <= cfg_wdata_i;
        bgsc_pkg::CfgIdxFull:  full_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q      <= cmd_word_i;
      chg_neg_q  <= charge_word_i[15];
      cur_neg_q  <= current_word_i[15];
      chg_prod_q <= bgsc_pkg::ChgProdW'(chg_mag * bgsc_pkg::ChargeFactor);
      cur_prod_q <= bgsc_pkg::CurProdW'(cur_mag * bgsc_pkg::CurrentFactor);
      volt_uv_q  <= bgsc_pkg::UvW'(voltage_word_i[11:0] * bgsc_pkg::UvPerCount);
      empty_uv_q <= bgsc_pkg::UvW'(empty_q * bgsc_pkg::UvPerMv);
      full_uv_q  <= bgsc_pkg::UvW'(full_q * bgsc_pkg::UvPerMv);
      temp_q     <= temperature_word_i;
    end
  end

  // divider operand selection
  assign volt_above = volt_uv_q - empty_uv_q;
  assign pct_num    = 31'(volt_above * bgsc_pkg::PctFull);
  assign sum_mag    = sum_q[bgsc_pkg::SumW-1] ? (~sum_q + 59'd1) : sum_q;

  always_comb begin
    case (cmd_i.op)
      bgsc_pkg::OP_CHG: begin
        div_num   = bgsc_pkg::DivNumW'(chg_prod_q);
        div_den   = bgsc_pkg::DivDenW'(res_eff);
        div_qbits = bgsc_pkg::QbitsChg;
      end
      bgsc_pkg::OP_CUR: begin
        div_num   = bgsc_pkg::DivNumW'(cur_prod_q);
        div_den   = bgsc_pkg::DivDenW'(res_eff);
        div_qbits = bgsc_pkg::QbitsCur;
      end
      bgsc_pkg::OP_PCT: begin
        div_num   = bgsc_pkg::DivNumW'(pct_num);
        div_den   = bgsc_pkg::DivDenW'(full_uv_q - empty_uv_q);
        div_qbits = bgsc_pkg::QbitsPct;
      end
      bgsc_pkg::OP_AVG: begin
        div_num   = bgsc_pkg::DivNumW'(sum_mag);
        div_den   = total_q;
        div_qbits = bgsc_pkg::QbitsAvg;
      end
      default: begin
        div_num   = '0;
        div_den   = '0;
        div_qbits = '0;
      end
    endcase
  end

  bgsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start),
    .num_i   (div_num),
    .den_i   (div_den),
    .qbits_i (div_qbits),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign div_done_o = div_done;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q <= cmd_i.op;
    end
  end

  // sign restore and saturation of the quotient
  always_comb begin
    quot_signed = 30'(div_quot);
    case (op_q)
      bgsc_pkg::OP_CHG: quot_signed = chg_neg_q ? -quot_signed : quot_signed;
      bgsc_pkg::OP_CUR: quot_signed = cur_neg_q ? -quot_signed : quot_signed;
      bgsc_pkg::OP_AVG: quot_signed = sum_q[bgsc_pkg::SumW-1] ? -quot_signed : quot_signed;
      default: ;
    endcase
  end

  assign chg_diff = {{4{quot_signed[29]}}, quot_signed} - {{2{ref_q[31]}}, ref_q};

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      case (op_q)
        bgsc_pkg::OP_CHG: charge_q  <= sat27(chg_diff);
        bgsc_pkg::OP_CUR: current_q <= sat27({{4{quot_signed[29]}}, quot_signed});
        bgsc_pkg::OP_PCT: pct_q     <= div_quot[bgsc_pkg::PctW-1:0];
        bgsc_pkg::OP_AVG: avg_q     <= quot_signed[bgsc_pkg::AvgW-1:0];
        default: ;
      endcase
    end
  end

  assign rebase_sum = {{6{last_rel_q[26]}}, last_rel_q} + {ref_q[31], ref_q};
  assign sum_next   = sum_q + {{(bgsc_pkg::SumW-bgsc_pkg::CurW){current_q[26]}}, current_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q      <= '0;
      last_rel_q <= '0;
      sum_q      <= '0;
      total_q    <= '0;
    end else if (cmd_i.update) begin
      case (cmd_q)
        bgsc_pkg::CmdSample: begin
          last_rel_q <= charge_q;
          if (total_q != '1) begin
            sum_q   <= sum_next;
            total_q <= total_q + 32'd1;
          end
        end
        bgsc_pkg::CmdRebase: begin
          if (rebase_sum[32] != rebase_sum[31]) begin
            ref_q <= rebase_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
          end else begin
            ref_q <= rebase_sum[31:0];
          end
          last_rel_q <= '0;
          sum_q      <= '0;
          total_q    <= '0;
        end
        bgsc_pkg::CmdClear: begin
          ref_q   <= '0;
          sum_q   <= '0;
          total_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // empty test first so inverted limits never use the quotient
  assign pct_low  = (volt_uv_q <= empty_uv_q);
  assign pct_high = (volt_uv_q >= full_uv_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cmd_q == bgsc_pkg::CmdSample) begin
        charge_uah_o          <= charge_q;
        current_ua_o          <= current_q;
        voltage_uv_o          <= volt_uv_q;
        temperature_eighths_o <= temp_q;
        if (pct_low) begin
          charge_percent_o <= '0;
        end else if (pct_high) begin
          charge_percent_o <= bgsc_pkg::PctFull;
        end else begin
          charge_percent_o <= pct_q;
        end
      end else begin
        charge_uah_o          <= '0;
        current_ua_o          <= '0;
        voltage_uv_o          <= '0;
        temperature_eighths_o <= '0;
        charge_percent_o      <= '0;
      end
      average_current_ua_o <= (total_q == '0) ? '0 : avg_q;
      samples_counted_o    <= total_q;
    end
  end

endmodule

// ===== design/bgsc_ctrl.sv =====
module bgsc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  logic                 div_done_i,
  output bgsc_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLoad = 3'd1;
  localparam logic [2:0] StChg  = 3'd2;
  localparam logic [2:0] StCur  = 3'd3;
  localparam logic [2:0] StUpd  = 3'd4;
  localparam logic [2:0] StPct  = 3'd5;
  localparam logic [2:0] StAvg  = 3'd6;
  localparam logic [2:0] StFin  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.op      = bgsc_pkg::OP_CHG;
    out_valid_d   = out_valid_q && out_stall_i;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StLoad;
        end
      end
      StLoad: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = bgsc_pkg::OP_CHG;
        state_d     = StChg;
      end
      StChg: begin
        if (div_done_i) begin
          cmd_o.start = 1'b1;
          cmd_o.op    = bgsc_pkg::OP_CUR;
          state_d     = StCur;
        end
      end
      StCur: begin
        if (div_done_i) begin
          state_d = StUpd;
        end
      end
      StUpd: begin
        cmd_o.update = 1'b1;
        cmd_o.start  = 1'b1;
        cmd_o.op     = bgsc_pkg::OP_PCT;
        state_d      = StPct;
      end
      StPct: begin
        if (div_done_i) begin
          cmd_o.start = 1'b1;
          cmd_o.op    = bgsc_pkg::OP_AVG;
          state_d     = StAvg;
        end
      end
      StAvg: begin
        if (div_done_i) begin
          state_d = StFin;
        end
      end
      StFin: begin
        // wait here while the previous word is still held
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule

// ===== design/battery_gauge_sample_converter.sv =====
// words are converted one at a time: a new word is taken only once the previous one
// has been loaded into the output register, which waits while a finished word is still stalled
// conversion uses the shared serial divider, one quotient bit per cycle over
// four divisions (charge, current, state of charge, average) of 28+29+7+27 bits
// reset: asynchronous, active low; clears charge reference, current sum and count,
// loads the default configuration and clears the output valid flag
module battery_gauge_sample_converter (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [bgsc_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  logic [bgsc_pkg::CfgDataW-1:0]          cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [bgsc_pkg::CmdW-1:0]              cmd_i,
  input  logic signed [bgsc_pkg::WordW-1:0]      charge_word_i,
  input  logic signed [bgsc_pkg::WordW-1:0]      current_word_i,
  input  logic [bgsc_pkg::WordW-1:0]             voltage_word_i,
  input  logic signed [bgsc_pkg::WordW-1:0]      temperature_word_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [bgsc_pkg::ChgW-1:0]       charge_uah_o,
  output logic signed [bgsc_pkg::CurW-1:0]       current_ua_o,
  output logic [bgsc_pkg::VoltW-1:0]             voltage_uv_o,
  output logic signed [bgsc_pkg::TempW-1:0]      temperature_eighths_o,
  output logic [bgsc_pkg::PctW-1:0]              charge_percent_o,
  output logic signed [bgsc_pkg::AvgW-1:0]       average_current_ua_o,
  output logic [bgsc_pkg::CountW-1:0]            samples_counted_o
);

  bgsc_pkg::ctrl_cmd_t ctrl_cmd;
  logic                div_done;

  bgsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .div_done_i  (div_done),
    .cmd_o       (ctrl_cmd)
  );

  bgsc_datapath u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (ctrl_cmd),
    .div_done_o            (div_done),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .cmd_word_i            (cmd_i),
    .charge_word_i         (charge_word_i),
    .current_word_i        (current_word_i),
    .voltage_word_i        (voltage_word_i),
    .temperature_word_i    (temperature_word_i),
    .charge_uah_o          (charge_uah_o),
    .current_ua_o          (current_ua_o),
    .voltage_uv_o          (voltage_uv_o),
    .temperature_eighths_o (temperature_eighths_o),
    .charge_percent_o      (charge_percent_o),
    .average_current_ua_o  (average_current_ua_o),
    .samples_counted_o     (samples_counted_o)
  );

  // the datapath latches a word exactly when the input side completes a handshake
  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.load == (in_valid_i && !in_stall_o))
    else $error("word latch out of step with input handshake");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not held off after accepting a word");

  a_div_not_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.start |=> !div_done)
    else $error("divider finished in the cycle after start");

  a_avg_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && samples_counted_o == '0) |-> average_current_ua_o == '0)
    else $error("average reported with no samples counted");

endmodule

// ===== sim/battery_gauge_sample_converter_tb.sv =====
module battery_gauge_sample_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bgsc_pkg::*;

  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  localparam longint ChgScale  = 6700;
  localparam longint CurScale  = 11770;
  localparam longint UvPerStep = 2440;
  localparam longint S27Max    = 67108863;
  localparam longint S27Min    = -67108864;
  localparam longint I32Max    = 2147483647;
  localparam longint I32Min    = -I32Max - 1;

  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned PhaseItems  = 250;
  localparam int unsigned PhaseCount  = 6;
  localparam int unsigned HoldCycles  = 600;
  localparam int unsigned TailCycles  = 120;

  typedef struct packed {
    logic [CmdW-1:0]         cmd;
    logic signed [WordW-1:0] charge;
    logic signed [WordW-1:0] current;
    logic [WordW-1:0]        volt;
    logic signed [WordW-1:0] temp;
  } gauge_word_t;

  typedef struct packed {
    logic signed [ChgW-1:0]  charge;
    logic signed [CurW-1:0]  current;
    logic [VoltW-1:0]        volt;
    logic signed [TempW-1:0] temp;
    logic [PctW-1:0]         pct;
    logic signed [AvgW-1:0]  avg;
    logic [CountW-1:0]       count;
  } gauge_result_t;

  typedef struct {
    logic                  is_cfg;
    logic [CfgIdxW-1:0]    idx;
    logic [CfgDataW-1:0]   val;
    gauge_word_t           w;
    logic                  typed;
    gauge_result_t         want;
  } plan_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CfgIdxW-1:0]      cfg_idx_i;
  logic [CfgDataW-1:0]     cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [CmdW-1:0]         cmd_i;
  logic signed [WordW-1:0] charge_word_i;
  logic signed [WordW-1:0] current_word_i;
  logic [WordW-1:0]        voltage_word_i;
  logic signed [WordW-1:0] temperature_word_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [ChgW-1:0]  charge_uah_o;
  logic signed [CurW-1:0]  current_ua_o;
  logic [VoltW-1:0]        voltage_uv_o;
  logic signed [TempW-1:0] temperature_eighths_o;
  logic [PctW-1:0]         charge_percent_o;
  logic signed [AvgW-1:0]  average_current_ua_o;
  logic [CountW-1:0]       samples_counted_o;

  battery_gauge_sample_converter uut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .cmd_i                 (cmd_i),
    .charge_word_i         (charge_word_i),
    .current_word_i        (current_word_i),
    .voltage_word_i        (voltage_word_i),
    .temperature_word_i    (temperature_word_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .charge_uah_o          (charge_uah_o),
    .current_ua_o          (current_ua_o),
    .voltage_uv_o          (voltage_uv_o),
    .temperature_eighths_o (temperature_eighths_o),
    .charge_percent_o      (charge_percent_o),
    .average_current_ua_o  (average_current_ua_o),
    .samples_counted_o     (samples_counted_o)
  );

  // gauge model state and its copy of the configuration
  logic [ResW-1:0]   res_mohm;
  logic [MvW-1:0]    empty_mv;
  logic [MvW-1:0]    full_mv;
  int                chg_ref;
  int                last_rel;
  longint            i_sum;
  logic [CountW-1:0] n_samples;

  gauge_result_t pending_results[$];
  plan_row_t     plan[$];

  int unsigned mismatch_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;

  function automatic longint clamp27(input longint v);
    if (v < S27Min) return S27Min;
    if (v > S27Max) return S27Max;
    return v;
  endfunction

  function automatic gauge_result_t gauge_convert(input gauge_word_t w);
    gauge_result_t r;
    longint div, q, cur, volt_uv, lo_uv, hi_uv, pct, avg, t;
    r = '0;
    avg = 0;
    div = (res_mohm == 0) ? 64'sd1 : longint'(res_mohm);
    if (w.cmd == CmdSample) begin
      q = clamp27(longint'(w.charge) * ChgScale / div - longint'(chg_ref));
      last_rel = int'(q);
      cur = clamp27(longint'(w.current) * CurScale / div);
      volt_uv = longint'(w.volt[11:0]) * UvPerStep;
      lo_uv = longint'(empty_mv) * 1000;
      hi_uv = longint'(full_mv) * 1000;
      // empty test first, so inverted limits never divide
      if (volt_uv <= lo_uv) pct = 0;
      else if (volt_uv >= hi_uv) pct = 100;
      else pct = (volt_uv - lo_uv) * 100 / (hi_uv - lo_uv);
      if (n_samples != 32'hFFFF_FFFF) begin
        i_sum += cur;
        n_samples++;
      end
      r.charge  = q[ChgW-1:0];
      r.current = cur[CurW-1:0];
      r.volt    = volt_uv[VoltW-1:0];
      r.temp    = w.temp;
      r.pct     = pct[PctW-1:0];
    end else if (w.cmd == CmdRebase) begin
      t = longint'(last_rel) + longint'(chg_ref);
      if (t > I32Max) t = I32Max;
      if (t < I32Min) t = I32Min;
      chg_ref = int'(t);
      last_rel = 0;
      i_sum = 0;
      n_samples = '0;
    end else if (w.cmd == CmdClear) begin
      chg_ref = 0;
      i_sum = 0;
      n_samples = '0;
    end
    if (n_samples != 0) avg = i_sum / longint'(n_samples);
    r.avg   = avg[AvgW-1:0];
    r.count = n_samples;
    return r;
  endfunction

  function automatic gauge_word_t mk_word(input logic [CmdW-1:0] cmd,
                                          input logic [WordW-1:0] chg, cur, volt, temp);
    gauge_word_t w;
    w.cmd = cmd;
    w.charge = chg;
    w.current = cur;
    w.volt = volt;
    w.temp = temp;
    return w;
  endfunction

  function automatic gauge_result_t mk_result(input longint chg, cur, volt, temp, pct, avg,
                                              cnt);
    gauge_result_t r;
    r.charge  = chg[ChgW-1:0];
    r.current = cur[CurW-1:0];
    r.volt    = volt[VoltW-1:0];
    r.temp    = temp[TempW-1:0];
    r.pct     = pct[PctW-1:0];
    r.avg     = avg[AvgW-1:0];
    r.count   = cnt[CountW-1:0];
    return r;
  endfunction

  function automatic logic [WordW-1:0] rand_raw();
    logic [WordW-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'h7FFF;
      1: v = 16'h8000;
      2: v = 16'h0000;
      3: v = 16'hFFFF;
      4: begin
        v = WordW'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = WordW'($urandom);
    endcase
    return v;
  endfunction

  function automatic gauge_word_t rand_word();
    gauge_word_t w;
    int unsigned pick;
    longint lim;
    logic [3:0] hi_bits;
    pick = $urandom_range(0, 99);
    if (pick < 84) w.cmd = CmdSample;
    else if (pick < 90) w.cmd = CmdRebase;
    else if (pick < 94) w.cmd = CmdClear;
    else w.cmd = CmdUnused;
    w.charge = rand_raw();
    w.current = rand_raw();
    w.temp = rand_raw();
    if ($urandom_range(0, 2) == 0) begin
      // land a few steps either side of a limit, upper nibble junk
      lim = longint'($urandom_range(0, 1) ? full_mv : empty_mv) * 1000 / UvPerStep
            + int'($urandom_range(0, 4)) - 2;
      if (lim < 0) lim = 0;
      if (lim > 4095) lim = 4095;
      hi_bits = 4'($urandom);
      w.volt = {hi_bits, lim[11:0]};
    end else begin
      w.volt = rand_raw();
    end
    return w;
  endfunction

  task automatic add_item(input gauge_word_t w);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.idx = '0;
    row.val = '0;
    row.w = w;
    row.typed = 1'b0;
    row.want = '0;
    plan.push_back(row);
  endtask

  task automatic add_typed(input gauge_word_t w, input gauge_result_t want);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.idx = '0;
    row.val = '0;
    row.w = w;
    row.typed = 1'b1;
    row.want = want;
    plan.push_back(row);
  endtask

  task automatic add_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    plan_row_t row;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.val = val;
    row.w = '0;
    row.typed = 1'b0;
    row.want = '0;
    plan.push_back(row);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CfgIdxRes) res_mohm = val[ResW-1:0];
    else if (idx == CfgIdxEmpty) empty_mv = val[MvW-1:0];
    else if (idx == CfgIdxFull) full_mv = val[MvW-1:0];
  endtask

  // offer one word, keep valid up until it is taken, then book its result
  task automatic send_word(input gauge_word_t w, input logic typed,
                           input gauge_result_t want);
    gauge_result_t pred;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    cmd_i = w.cmd;
    charge_word_i = w.charge;
    current_word_i = w.current;
    voltage_word_i = w.volt;
    temperature_word_i = w.temp;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pred = gauge_convert(w);
    pending_results.push_back(typed ? want : pred);
  endtask

  task automatic quiesce();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("** battery_gauge_sample_converter: FAILED **");
    $finish;
  end

  // receiver: random stall, or a long hold when asked
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    gauge_result_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.charge  = charge_uah_o;
      got.current = current_ua_o;
      got.volt    = voltage_uv_o;
      got.temp    = temperature_eighths_o;
      got.pct     = charge_percent_o;
      got.avg     = average_current_ua_o;
      got.count   = samples_counted_o;
      if (pending_results.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("unexpected result word: chg %0d cur %0d uv %0d t %0d pct %0d avg %0d n %0d",
                   got.charge, got.current, got.volt, got.temp, got.pct, got.avg, got.count);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (mismatch_cnt < 10) begin
            $display("mismatch exp: chg %0d cur %0d uv %0d t %0d pct %0d avg %0d n %0d",
                     want.charge, want.current, want.volt, want.temp, want.pct, want.avg,
                     want.count);
            $display("         got: chg %0d cur %0d uv %0d t %0d pct %0d avg %0d n %0d",
                     got.charge, got.current, got.volt, got.temp, got.pct, got.avg,
                     got.count);
          end
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned ph;
    int unsigned lo;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    cmd_i = CmdSample;
    charge_word_i = '0;
    current_word_i = '0;
    voltage_word_i = '0;
    temperature_word_i = '0;
    res_mohm = ResReset;
    empty_mv = EmptyReset;
    full_mv = FullReset;
    chg_ref = 0;
    last_rel = 0;
    i_sum = 0;
    n_samples = '0;
    send_idle_pct = 26;
    recv_idle_pct = 72;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset configuration: 100 mohm, 3000..4200 mV
    add_typed(mk_word(CmdUnused, 0, 0, 0, 0), mk_result(0, 0, 0, 0, 0, 0, 0));
    add_typed(mk_word(CmdSample, 0, 0, 0, 0), mk_result(0, 0, 0, 0, 0, 0, 1));
    add_typed(mk_word(CmdSample, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h7FFF),
              mk_result(2195389, 3856675, 9991800, 32767, 100, 1928337, 2));
    // high bits of the voltage word are dropped
    add_typed(mk_word(CmdSample, 16'h8000, 16'h8000, 16'hF000, 16'h8000),
              mk_result(-2195456, -3856793, 0, -32768, 0, -39, 3));
    add_typed(mk_word(CmdRebase, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0),
              mk_result(0, 0, 0, 0, 0, 0, 0));
    // either side of both limits
    add_item(mk_word(CmdSample, 0, 100, 1229, 5));
    add_item(mk_word(CmdSample, 1, -100, 1230, -5));
    add_item(mk_word(CmdSample, -1, 1, 1475, 8));
    add_item(mk_word(CmdSample, 12000, -1, 1721, -8));
    add_item(mk_word(CmdSample, -12000, 2000, 1722, 800));
    add_item(mk_word(CmdUnused, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    add_typed(mk_word(CmdClear, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
              mk_result(0, 0, 0, 0, 0, 0, 0));
    // clear leaves the last relative charge for a following rebase
    add_item(mk_word(CmdRebase, 0, 0, 0, 0));
    add_item(mk_word(CmdSample, 100, 100, 100, 100));
    // zero resistance behaves as one milliohm, so charge and current saturate
    add_cfg(CfgIdxRes, 0);
    add_item(mk_word(CmdSample, 16'h7FFF, 16'h7FFF, 16'h0800, 0));
    add_item(mk_word(CmdSample, 16'h8000, 16'h8000, 16'h0800, 0));
    add_item(mk_word(CmdRebase, 0, 0, 0, 0));
    add_item(mk_word(CmdSample, 16'h8000, 16'h8000, 16'h0400, 0));
    add_item(mk_word(CmdSample, 16'h7FFF, 16'h7FFF, 16'h0400, 0));
    // equal limits
    add_cfg(CfgIdxRes, 1);
    add_cfg(CfgIdxEmpty, 5000);
    add_cfg(CfgIdxFull, 5000);
    add_item(mk_word(CmdSample, 3, 3, 2049, 1));
    add_item(mk_word(CmdSample, -3, -3, 2050, -1));
    // inverted limits
    add_cfg(CfgIdxEmpty, 6000);
    add_cfg(CfgIdxFull, 2000);
    add_item(mk_word(CmdSample, 7, 7, 16'h0FFF, 2));
    add_item(mk_word(CmdSample, -7, -7, 2000, -2));
    add_cfg(CfgIdxRes, 1000);
    add_cfg(CfgIdxEmpty, 0);
    add_cfg(CfgIdxFull, 10000);
    add_item(mk_word(CmdSample, 16'h7FFF, 16'h7FFF, 16'h0FFF, 16'h7FFF));
    add_item(mk_word(CmdSample, 16'h8000, 16'h8000, 16'h0000, 16'h8000));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        quiesce();
        cfg_write(plan[i].idx, plan[i].val);
      end else begin
        send_word(plan[i].w, plan[i].typed, plan[i].want);
      end
    end
    quiesce();

    for (ph = 0; ph < PhaseCount; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 26;
        recv_idle_pct = 72;
      end else if (ph < 4) begin
        send_idle_pct = 72;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: begin
          cfg_write(CfgIdxRes, CfgDataW'($urandom_range(10, 1000)));
          cfg_write(CfgIdxEmpty, 3000);
          cfg_write(CfgIdxFull, 4200);
        end
        1: begin
          cfg_write(CfgIdxRes, 10);
          cfg_write(CfgIdxEmpty, 0);
          cfg_write(CfgIdxFull, 10000);
        end
        2: begin
          cfg_write(CfgIdxRes, 1000);
          cfg_write(CfgIdxEmpty, CfgDataW'($urandom_range(0, 10000)));
          cfg_write(CfgIdxFull, CfgDataW'($urandom_range(0, 10000)));
        end
        3: begin
          cfg_write(CfgIdxRes, CfgDataW'($urandom_range(0, 9)));
          cfg_write(CfgIdxEmpty, 2500);
          cfg_write(CfgIdxFull, 4500);
        end
        4: begin
          cfg_write(CfgIdxRes, CfgDataW'($urandom_range(10, 1000)));
          cfg_write(CfgIdxEmpty, 10000);
          cfg_write(CfgIdxFull, 0);
        end
        default: begin
          lo = $urandom_range(2000, 4000);
          cfg_write(CfgIdxRes, CfgDataW'($urandom_range(10, 1000)));
          cfg_write(CfgIdxEmpty, CfgDataW'(lo));
          cfg_write(CfgIdxFull, CfgDataW'(lo + $urandom_range(1, 3000)));
        end
      endcase
      if (ph == 4) begin
        // long receiver hold so the block backs up into its input
        @(posedge clk_i);
        hold_left = HoldCycles;
      end
      repeat (PhaseItems) send_word(rand_word(), 1'b0, '0);
      quiesce();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("** battery_gauge_sample_converter: PASSED **");
    end else begin
      $display("** battery_gauge_sample_converter: FAILED **");
    end
    $finish;
  end

endmodule
